// ===== sv/kcl_pkg.sv =====
// Shared types, constants and key decoding for the keypad code lock.
package kcl_pkg;

    localparam int CODE_DIGITS = 4;
    localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
    localparam int CODE_W      = 16;

    localparam logic [CODE_W-1:0] SECRET_RESET = 16'h7196;

    localparam logic [3:0] KEY_STAR = 4'd10;
    localparam logic [3:0] KEY_HASH = 4'd11;

    localparam logic [1:0] ROW_STAR_HASH = 2'd3;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PROMPT  = 3'd1;
    localparam logic [2:0] EV_CLEARED = 3'd2;
    localparam logic [2:0] EV_ECHO    = 3'd3;
    localparam logic [2:0] EV_WELCOME = 3'd4;
    localparam logic [2:0] EV_WRONG   = 3'd5;

    typedef struct packed {
        logic             armed;
        logic [CNT_W-1:0] digit_count;
        logic             relay;
        logic [1:0]       scan_row;
        logic             awaiting;
        logic [1:0]       held_col;
        logic [3:0]       held_key;
    } t_lock_state;

    typedef logic [CODE_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        logic [2:0] display_event;
        logic [3:0] key_code;
        logic       key_valid;
        logic       relay_on;
        logic [1:0] row_drive;
    } t_result;

    localparam t_lock_state STATE_RESET = '{
        armed:       1'b0,
        digit_count: '0,
        relay:       1'b0,
        scan_row:    2'd0,
        awaiting:    1'b0,
        held_col:    2'd0,
        held_key:    4'd0
    };

    function automatic logic [3:0] key_map(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] key;
        unique case ({row, col})
            4'b00_00: key = 4'd1;
            4'b00_01: key = 4'd2;
            4'b00_10: key = 4'd3;
            4'b01_00: key = 4'd4;
            4'b01_01: key = 4'd5;
            4'b01_10: key = 4'd6;
            4'b10_00: key = 4'd7;
            4'b10_01: key = 4'd8;
            4'b10_10: key = 4'd9;
            4'b11_00: key = KEY_STAR;
            4'b11_01: key = 4'd0;
            4'b11_10: key = KEY_HASH;
            default:  key = 4'd0;
        endcase
        return key;
    endfunction

endpackage

// ===== sv/kcl_step.sv =====
// Next-state and result logic for one keypad scan tick.
module kcl_step
    import kcl_pkg::*;
(
    input  t_lock_state       i_state,
    input  t_digits           i_digits,
    input  logic [2:0]        i_cols,
    input  logic [CODE_W-1:0] i_secret,
    output t_lock_state       o_state,
    output t_digits           o_digits,
    output t_result           o_result
);

    logic [3:0]         cols_ext;
    logic [31:0]        code_ext;
    logic [1:0]         row;
    logic               col_hit;
    logic [1:0]         col;
    logic [CNT_W:0]     count_inc;
    logic               match;
    logic [3:0]         digit;
    logic [2:0]         event_code;
    logic               key_valid;

    assign cols_ext  = {1'b0, i_cols};
    assign code_ext  = 32'(i_secret);
    assign count_inc = {1'b0, i_state.digit_count} + (CNT_W+1)'(1);
    assign row       = i_state.armed ? i_state.scan_row : ROW_STAR_HASH;

    // The final digit is compared together with the digits already stored.
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            digit = (i_state.digit_count == CNT_W'(i)) ? i_state.held_key : i_digits[i];
            if (digit != code_ext[4*(CODE_DIGITS-1-i) +: 4]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        col_hit = 1'b1;
        col     = 2'd0;
        priority if (i_cols[0]) begin
            col = 2'd0;
        end else if (i_cols[1] && i_state.armed) begin
            col = 2'd1;
        end else if (i_cols[2]) begin
            col = 2'd2;
        end else begin
            col_hit = 1'b0;
        end
    end

    always_comb begin
        o_state    = i_state;
        o_digits   = i_digits;
        key_valid  = 1'b0;
        event_code = EV_NONE;
        if (i_state.awaiting) begin
            if (!cols_ext[i_state.held_col]) begin
                o_state.awaiting = 1'b0;
                o_state.scan_row = 2'd0;
                key_valid        = 1'b1;
                if (i_state.held_key == KEY_STAR) begin
                    o_state.armed       = 1'b1;
                    o_state.digit_count = '0;
                    event_code          = EV_PROMPT;
                end else if (i_state.held_key == KEY_HASH) begin
                    o_state.digit_count = '0;
                    o_state.relay       = 1'b0;
                    event_code          = EV_CLEARED;
                end else begin
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (i_state.digit_count == CNT_W'(i)) begin
                            o_digits[i] = i_state.held_key;
                        end
                    end
                    if (count_inc >= (CNT_W+1)'(CODE_DIGITS)) begin
                        o_state.armed       = 1'b0;
                        o_state.digit_count = '0;
                        o_state.relay       = match;
                        event_code          = match ? EV_WELCOME : EV_WRONG;
                    end else begin
                        o_state.digit_count = count_inc[CNT_W-1:0];
                        event_code          = EV_ECHO;
                    end
                end
            end
        end else if (col_hit) begin
            o_state.awaiting = 1'b1;
            o_state.held_col = col;
            o_state.held_key = key_map(row, col);
        end else if (i_state.armed) begin
            o_state.scan_row = i_state.scan_row + 2'd1;
        end
    end

    always_comb begin
        o_result.row_drive     = o_state.armed ? o_state.scan_row : ROW_STAR_HASH;
        o_result.relay_on      = o_state.relay;
        o_result.key_valid     = key_valid;
        o_result.key_code      = key_valid ? i_state.held_key : 4'd0;
        o_result.display_event = event_code;
    end

endmodule

// ===== sv/keypad_code_lock_unit.sv =====
// Keypad code lock top level: input register, lock state and result register.
//
//  channel   dir  handshake                 payload
//  s (in)    in   i_s_tvalid / o_s_tready   i_s_tdata  [7:0]  column sample
//  m (out)   out  o_m_tvalid / i_m_tready   o_m_tdata [15:0]  scan result
//  cfg       in   i_cfg_wr_en               i_cfg_wr_data [15:0] secret code
//
// Each beat passes through the input register, then through the step logic into the result
// register. A new beat is accepted every cycle while the output is not stalled;
// the lock state is updated once per beat.
// Reset returns the lock to disarmed, relay off, and the code to 0x7196.
// A stalled output holds its beat while one more input beat waits in the input register.
module keypad_code_lock_unit
    import kcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [2:0] column_sense, [7:3] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // [1:0] row_drive, [2] relay_on, [3] key_valid,
                                       // [7:4] key_code, [10:8] display_event, [15:11] zero
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic              r_in_valid;
    logic [2:0]        r_in_cols;
    logic              r_out_valid;
    t_result           r_out;
    t_lock_state       r_state;
    t_digits           r_digits;
    logic [CODE_W-1:0] r_secret;

    t_lock_state       n_state;
    t_digits           n_digits;
    t_result           n_out;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out};

    kcl_step u_step (
        .i_state  (r_state),
        .i_digits (r_digits),
        .i_cols   (r_in_cols),
        .i_secret (r_secret),
        .o_state  (n_state),
        .o_digits (n_digits),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_secret    <= SECRET_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_secret <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cols <= i_s_tdata[2:0];
        end
        if (advance) begin
            r_out    <= n_out;
            r_digits <= n_digits;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digit_count < CNT_W'(CODE_DIGITS))
        else $error("digit count reached the code length");

    a_held_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held_col != 2'd3)
        else $error("held column out of range");

    a_event_with_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.key_valid |-> r_out.display_event != EV_NONE)
        else $error("accepted key produced no display event");

    a_welcome_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.display_event == EV_WELCOME |-> r_out.relay_on)
        else $error("welcome reported with relay off");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled while result register empty");
`endif

endmodule
